// ===== rtl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbc_pkg
// shared types, constants and the luma function of the brightness
// centroid unit
// ----------------------------------------------------------------------------
package tbc_pkg;

  // frame geometry and result format
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // field widths
  localparam int CHAN_W  = 8;
  localparam int COUNT_W = 25;
  localparam int SUM_W   = 36;
  localparam int CENT_W  = 20;

  // dividend split: sum << FRAC_BITS, upper part enters the remainder
  localparam int SPLIT      = CENT_W - FRAC_BITS;
  localparam int QIDX_W     = $clog2(CENT_W);

  // luma weights, rounded fixed point
  localparam int LUMA_W     = 22;
  localparam int LUMA_SHIFT = 14;
  localparam logic [LUMA_W-1:0] W_BLUE     = LUMA_W'(1868);
  localparam logic [LUMA_W-1:0] W_GREEN    = LUMA_W'(9617);
  localparam logic [LUMA_W-1:0] W_RED      = LUMA_W'(4899);
  localparam logic [LUMA_W-1:0] LUMA_ROUND = LUMA_W'(8192);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  // register port
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = ADDR_W'(0);

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              line_end;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [CENT_W-1:0]  centroid_x;
    logic [CENT_W-1:0]  centroid_y;
    logic [COUNT_W-1:0] bright_count;
  } result_t;

  // accumulated totals of one finished frame
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
  } frame_rec_t;

  function automatic logic [CHAN_W-1:0] luma(input pixel_t p);
    logic [LUMA_W-1:0] acc;
    acc = W_BLUE * LUMA_W'(p.blue) + W_GREEN * LUMA_W'(p.green)
        + W_RED * LUMA_W'(p.red) + LUMA_ROUND;
    return acc[LUMA_SHIFT +: CHAN_W];
  endfunction

endpackage

// ===== rtl/tbc_front.sv =====
// ----------------------------------------------------------------------------
// tbc_front
// pixel intake: gray conversion, coordinate tracking, bright accumulation
// ----------------------------------------------------------------------------
module tbc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  tbc_pkg::pixel_t           pixel,
  input  logic [7:0]                threshold,
  input  logic [tbc_pkg::QLEVEL_W-1:0] q_level,
  output logic                      rec_push,
  output tbc_pkg::frame_rec_t       rec
);
  import tbc_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_HEIGHT - 1);

  logic              accept;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  // stage 1: gray value and coordinates of the accepted pixel
  logic              s1_valid;
  logic              s1_fe;
  logic [CHAN_W-1:0] s1_gray;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;

  // accumulators
  logic [COUNT_W-1:0] cnt;
  logic [SUM_W-1:0]   col_sum;
  logic [SUM_W-1:0]   row_sum;

  logic               bright;
  logic [COUNT_W:0]   cnt_add;
  logic [SUM_W:0]     col_add;
  logic [SUM_W:0]     row_add;
  logic [QLEVEL_W:0]  committed;

  // a frame end waiting in stage 1 already owns a queue slot
  assign committed = {1'b0, q_level} + (QLEVEL_W+1)'(s1_valid & s1_fe);
  assign full      = committed >= (QLEVEL_W+1)'(QUEUE_DEPTH);
  assign accept    = push & ~full;

  assign bright  = s1_gray > threshold;
  assign cnt_add = {1'b0, cnt} + (COUNT_W+1)'(1);
  assign col_add = {1'b0, col_sum} + (SUM_W+1)'(s1_col);
  assign row_add = {1'b0, row_sum} + (SUM_W+1)'(s1_row);

  // saturating accumulation of the stage 1 pixel
  always_comb begin
    rec.count   = cnt;
    rec.col_sum = col_sum;
    rec.row_sum = row_sum;
    if (bright) begin
      rec.count   = cnt_add[COUNT_W] ? '1 : cnt_add[COUNT_W-1:0];
      rec.col_sum = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
      rec.row_sum = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
    end
  end

  assign rec_push = s1_valid & s1_fe;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gray <= luma(pixel);
      s1_col  <= col;
      s1_row  <= row;
      s1_fe   <= pixel.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
      cnt      <= '0;
      col_sum  <= '0;
      row_sum  <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (pixel.frame_end) begin
          col <= '0;
          row <= '0;
        end else if (pixel.line_end) begin
          col <= '0;
          if (row != ROW_MAX) begin
            row <= row + ROW_W'(1);
          end
        end else if (col != COL_MAX) begin
          col <= col + COL_W'(1);
        end
      end
      if (s1_valid) begin
        if (s1_fe) begin
          cnt     <= '0;
          col_sum <= '0;
          row_sum <= '0;
        end else begin
          cnt     <= rec.count;
          col_sum <= rec.col_sum;
          row_sum <= rec.row_sum;
        end
      end
    end
  end

endmodule

// ===== rtl/tbc_queue.sv =====
// ----------------------------------------------------------------------------
// tbc_queue
// short queue of finished frame totals between front and back
// ----------------------------------------------------------------------------
module tbc_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  tbc_pkg::frame_rec_t          wr_data,
  input  logic                         rd,
  output tbc_pkg::frame_rec_t          rd_data,
  output logic                         not_empty,
  output logic [tbc_pkg::QLEVEL_W-1:0] level
);
  import tbc_pkg::*;

  frame_rec_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_rd;

  assign not_empty = level != '0;
  assign do_rd     = rd & not_empty;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (wr && !do_rd) begin
        level <= level + QLEVEL_W'(1);
      end else if (!wr && do_rd) begin
        level <= level - QLEVEL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/tbc_back.sv =====
// ----------------------------------------------------------------------------
// tbc_back
// centroid division, one quotient bit per cycle, and the result register
// ----------------------------------------------------------------------------
module tbc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  tbc_pkg::frame_rec_t q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output tbc_pkg::result_t    result
);
  import tbc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]         state;
  logic               phase;  // 0: column sum, 1: row sum
  logic [QIDX_W-1:0]  idx;

  logic [COUNT_W-1:0] cnt;
  logic [SUM_W-1:0]   col_sum;
  logic [SUM_W-1:0]   row_sum;
  logic [COUNT_W-1:0] rem;
  logic [CENT_W-1:0]  dvd;
  logic [CENT_W-1:0]  quo;
  logic               sat;
  logic [CENT_W-1:0]  cent_x;
  logic [CENT_W-1:0]  cent_y;
  logic               out_valid;

  logic [SUM_W-1:0]   sum_sel;
  logic [COUNT_W:0]   rem_sh;
  logic               ge;
  logic [COUNT_W:0]   rem_next;
  logic [CENT_W-1:0]  quo_next;
  logic [CENT_W-1:0]  cent_val;
  logic               out_load;

  assign sum_sel  = phase ? row_sum : col_sum;
  assign rem_sh   = {rem, dvd[CENT_W-1]};
  assign ge       = rem_sh >= {1'b0, cnt};
  assign rem_next = ge ? rem_sh - {1'b0, cnt} : rem_sh;
  assign quo_next = {quo[CENT_W-2:0], ge};

  always_comb begin
    if (cnt == '0) begin
      cent_val = '0;
    end else if (sat) begin
      cent_val = '1;
    end else begin
      cent_val = quo_next;
    end
  end

  assign q_pop    = (state == ST_IDLE) & q_valid;
  assign out_load = (state == ST_HOLD) & (~out_valid | pop);
  assign empty    = ~out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cnt     <= q_data.count;
      col_sum <= q_data.col_sum;
      row_sum <= q_data.row_sum;
    end
    if (state == ST_INIT) begin
      rem <= COUNT_W'(sum_sel[SUM_W-1:SPLIT]);
      dvd <= {sum_sel[SPLIT-1:0], {FRAC_BITS{1'b0}}};
      // quotient overflows the result when sum >= count * 2^SPLIT
      sat <= {1'b0, sum_sel} >= {cnt, {SPLIT{1'b0}}};
      idx <= QIDX_W'(CENT_W - 1);
    end
    if (state == ST_STEP) begin
      rem <= rem_next[COUNT_W-1:0];
      dvd <= {dvd[CENT_W-2:0], 1'b0};
      quo <= quo_next;
      idx <= idx - QIDX_W'(1);
      if (idx == '0) begin
        if (phase) begin
          cent_y <= cent_val;
        end else begin
          cent_x <= cent_val;
        end
      end
    end
    if (out_load) begin
      result.found        <= cnt != '0;
      result.centroid_x   <= cent_x;
      result.centroid_y   <= cent_y;
      result.bright_count <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            phase <= 1'b0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (idx == '0) begin
            if (phase) begin
              state <= ST_HOLD;
            end else begin
              phase <= 1'b1;
              state <= ST_INIT;
            end
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/thresholded_brightness_centroid_unit.sv =====
// ----------------------------------------------------------------------------
// thresholded_brightness_centroid_unit
// centroid of the bright pixels of a streamed frame
// ----------------------------------------------------------------------------
// Pixels enter one per cycle through push/full, in row order, each with its
// line and frame end marks. Each pixel is turned into a rounded fixed-point
// luma value; a pixel is bright when that value is strictly above the
// bright_threshold register (byte address 0, reset 0). The front keeps the
// bright count and the saturating sums of the bright columns and rows; the
// column stops at 4095 within a row and the row stops at 4095 within a frame.
// The frame end pixel closes the frame: its totals go into a four-entry queue
// and the accumulators clear. The back divides each sum by the count with a
// restoring divider, one quotient bit per cycle, giving 8 fractional bits and
// saturating at 2^20 - 1; an empty frame reports found = 0 and zero centroids.
// One result comes out per frame through empty/pop. Pixel intake sustains one
// transfer per cycle while full is low; each frame result takes the divider
// two 20-step divisions plus setup, so a run of short frames can fill the
// queue and full then holds the input until the divider catches up.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module thresholded_brightness_centroid_unit (
  input  logic                       clk,
  input  logic                       rst,
  // pixel input
  input  logic                       push,
  output logic                       full,
  input  tbc_pkg::pixel_t            pixel,
  // frame results
  output logic                       empty,
  input  logic                       pop,
  output tbc_pkg::result_t           result,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbc_pkg::ADDR_W-1:0] paddr,
  input  logic [tbc_pkg::DATA_W-1:0] pwdata,
  output logic [tbc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import tbc_pkg::*;

  // threshold register
  logic [7:0] bright_threshold;

  // front to queue
  logic                rec_push;
  frame_rec_t          rec;

  // queue to back
  frame_rec_t          q_data;
  logic                q_valid;
  logic                q_pop;
  logic [QLEVEL_W-1:0] q_level;

  // register port: no wait states, write in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_threshold <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
      bright_threshold <= pwdata[7:0];
    end
  end

  // reads return the threshold, other addresses read as zero
  assign prdata = (paddr == ADDR_THRESHOLD) ? DATA_W'(bright_threshold) : '0;

  // front: luma, coordinates and bright accumulation
  tbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .threshold (bright_threshold),
    .q_level   (q_level),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // per-frame totals waiting for the divider
  tbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (rec_push),
    .wr_data   (rec),
    .rd        (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .level     (q_level)
  );

  // back: centroid division and result register
  tbc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== tb/thresholded_brightness_centroid_unit_test.sv =====
// ----------------------------------------------------------------------------
// thresholded_brightness_centroid_unit_test
// self-checking regression of the brightness centroid unit
// ----------------------------------------------------------------------------
// Frames of pixels go in through push/full. Frame results come out through
// empty/pop. A predictor follows every accepted pixel transfer. It keeps its
// own threshold, column and row position and saturating totals, and queues
// the expected result of each frame at its frame end pixel. Every popped
// result is checked field by field against the oldest queued frame.
// The named tests cover:
//   - the register reset value and readback
//   - a short directed set of channel extremes, threshold edges and marks
//   - column and row saturation in oversized frames
//   - a long receiver hold that fills the result queue and stalls the input
//   - random frames, ragged frames and noise over several thresholds
// The sender paces in random bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module thresholded_brightness_centroid_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbc_pkg::*;

  // luma weights, rounded fixed point with a 14 bit shift
  localparam int unsigned LUMA_B    = 1868;
  localparam int unsigned LUMA_G    = 9617;
  localparam int unsigned LUMA_R    = 4899;
  localparam int unsigned LUMA_HALF = 8192;
  localparam int          LUMA_SH   = 14;

  // saturation points of the frame totals
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam logic [SUM_W-1:0]   SUM_TOP   = '1;
  localparam logic [CENT_W-1:0]  CENT_TOP  = '1;
  localparam logic [COL_W-1:0]   COL_TOP   = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0]   ROW_TOP   = ROW_W'(MAX_HEIGHT - 1);

  // two divisions plus setup, with the queue behind them
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 1900;
  localparam int MAX_REPORTS   = 50;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                push    = 1'b0;
  logic                full;
  pixel_t              pixel   = '0;
  logic                empty;
  logic                pop     = 1'b0;
  result_t             result;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state, mirrors the block after every accepted pixel
  logic [7:0]          thr_shadow   = '0;
  logic [COL_W-1:0]    cur_col      = '0;
  logic [ROW_W-1:0]    cur_row      = '0;
  logic [COUNT_W-1:0]  bright_total = '0;
  logic [SUM_W-1:0]    col_total    = '0;
  logic [SUM_W-1:0]    row_total    = '0;
  result_t             pending_centroids[$];

  int                  mismatch_count = 0;
  int                  pixels_sent    = 0;
  int                  burst_left     = 0;
  bit                  pace_enable    = 1'b1;
  bit                  hold_request   = 1'b0;

  thresholded_brightness_centroid_unit dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  function automatic logic [CHAN_W-1:0] gray_level(input pixel_t px);
    int unsigned weighted;
    weighted = LUMA_B * px.blue + LUMA_G * px.green + LUMA_R * px.red + LUMA_HALF;
    return CHAN_W'(weighted >> LUMA_SH);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [15:0] step);
    logic [63:0] total;
    total = 64'(acc) + 64'(step);
    return (total > 64'(SUM_TOP)) ? SUM_TOP : SUM_W'(total);
  endfunction

  // sum / count with FRAC_BITS fraction bits, clipped to the field
  function automatic logic [CENT_W-1:0] centroid_of(input logic [SUM_W-1:0] sum,
                                                    input logic [COUNT_W-1:0] cnt);
    logic [63:0] quotient;
    if (cnt == '0) return '0;
    quotient = (64'(sum) << FRAC_BITS) / 64'(cnt);
    if (quotient > 64'(CENT_TOP)) quotient = 64'(CENT_TOP);
    return CENT_W'(quotient);
  endfunction

  // fold one accepted pixel into the frame totals; a frame end queues the
  // expected result and clears everything
  task automatic accumulate_pixel(input pixel_t px);
    result_t frame_done;
    if (gray_level(px) > thr_shadow) begin
      if (bright_total != COUNT_TOP) bright_total++;
      col_total = sat_sum(col_total, 16'(cur_col));
      row_total = sat_sum(row_total, 16'(cur_row));
    end
    if (px.frame_end) begin
      frame_done.found        = (bright_total != '0);
      frame_done.centroid_x   = centroid_of(col_total, bright_total);
      frame_done.centroid_y   = centroid_of(row_total, bright_total);
      frame_done.bright_count = bright_total;
      pending_centroids.push_back(frame_done);
      cur_col      = '0;
      cur_row      = '0;
      bright_total = '0;
      col_total    = '0;
      row_total    = '0;
    end else if (px.line_end) begin
      // next row, the row index holds at its top
      cur_col = '0;
      if (cur_row != ROW_TOP) cur_row++;
    end else if (cur_col != COL_TOP) begin
      cur_col++;
    end
  endtask

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_frame_result(input result_t got);
    result_t want;
    if (pending_centroids.size() == 0) begin
      report_mismatch("result with no frame pending", got.bright_count, '0);
      return;
    end
    want = pending_centroids.pop_front();
    if (got.found !== want.found)
      report_mismatch("found", got.found, want.found);
    if (got.centroid_x !== want.centroid_x)
      report_mismatch("centroid_x", got.centroid_x, want.centroid_x);
    if (got.centroid_y !== want.centroid_y)
      report_mismatch("centroid_y", got.centroid_y, want.centroid_y);
    if (got.bright_count !== want.bright_count)
      report_mismatch("bright_count", got.bright_count, want.bright_count);
  endtask

  // result side: checks each transfer, then picks pop for the next edge
  // from a stall style that changes every segment; a hold request keeps pop
  // low for a long stretch so the block backs up into full
  initial begin : result_sink
    int segment_left;
    int stall_style;
    int hold_left;
    int cycle_no;
    segment_left = 0;
    stall_style  = 0;
    hold_left    = 0;
    cycle_no     = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_frame_result(result);
      cycle_no++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (segment_left == 0) begin
        segment_left = $urandom_range(16, 160);
        stall_style  = $urandom_range(0, 3);
      end
      segment_left--;
      if (rst || hold_left > 0) begin
        pop <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        case (stall_style)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= (cycle_no % 3 == 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------

  // one pixel transfer; between bursts the sender may drop push for a gap
  task automatic send_pixel(input pixel_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (pace_enable && $urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    burst_left--;
    push  <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    accumulate_pixel(px);
    pixels_sent++;
  endtask

  // stop offering, wait for every queued frame, then let the divider settle
  task automatic drain_results();
    push <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access phase, then psel drops and the bus goes back to idle
  task automatic apb_transfer(input logic write, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // only between frames, once the block has gone quiet
  task automatic set_threshold(input logic [7:0] level);
    logic [DATA_W-1:0] readback;
    drain_results();
    apb_transfer(1'b1, ADDR_THRESHOLD, DATA_W'(level), readback);
    thr_shadow = level;
    apb_transfer(1'b0, ADDR_THRESHOLD, '0, readback);
    if (readback[7:0] !== level)
      report_mismatch("bright_threshold readback", readback, level);
  endtask

  function automatic pixel_t make_pixel(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r, input bit le, input bit fe);
    pixel_t px;
    px.blue      = b;
    px.green     = g;
    px.red       = r;
    px.line_end  = le;
    px.frame_end = fe;
    return px;
  endfunction

  // mix of free channels, grays right at the threshold and saturated channels
  function automatic pixel_t random_pixel();
    int unsigned pick;
    int          level;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0);
    end else if (pick < 8) begin
      // equal channels give a gray of exactly that value
      level = int'(thr_shadow) + int'($urandom_range(0, 4)) - 2;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      return make_pixel(8'(level), 8'(level), 8'(level), 1'b0, 1'b0);
    end
    return make_pixel({8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}, 1'b0, 1'b0);
  endfunction

  // mostly small frames; a ragged frame varies its row lengths and may end
  // early without a line end
  task automatic send_frame(input bit ragged);
    int     cols;
    int     rows;
    int     row_len;
    pixel_t px;
    cols = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    rows = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    for (int r = 0; r < rows; r++) begin
      row_len = ragged ? $urandom_range(1, cols + 3) : cols;
      for (int c = 0; c < row_len; c++) begin
        px = random_pixel();
        px.line_end  = (c == row_len - 1);
        px.frame_end = (r == rows - 1) && (c == row_len - 1);
        if (ragged && $urandom_range(0, 31) == 0) px.frame_end = 1'b1;
        send_pixel(px);
        if (px.frame_end) return;
      end
    end
  endtask

  task automatic send_noise(input int count);
    pixel_t px;
    repeat (count) begin
      px = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
      px.frame_end = ($urandom_range(0, 5) == 0);
      send_pixel(px);
    end
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  task automatic test_register_reset();
    logic [DATA_W-1:0] readback;
    apb_transfer(1'b0, ADDR_THRESHOLD, '0, readback);
    if (readback[7:0] !== 8'd0) report_mismatch("bright_threshold reset", readback, 0);
  endtask

  task automatic test_directed_pixels();
    set_threshold(8'd0);
    // 3x2 frame: black, white, single channels, both marks on the last pixel
    send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd0,   8'd0,   1'b1, 1'b0));
    send_pixel(make_pixel(8'd0,   8'd255, 8'd0,   1'b0, 1'b0));
    send_pixel(make_pixel(8'd0,   8'd0,   8'd255, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   1'b1, 1'b1));
    // one pixel frame, frame end alone, bright at the origin
    send_pixel(make_pixel(8'd1,   8'd1,   8'd1,   1'b0, 1'b1));
    // dark frame, no bright pixel
    send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0));
    send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   1'b1, 1'b1));
    // gray equal to the threshold is not bright, one above is
    set_threshold(8'd128);
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd129, 8'd129, 8'd129, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd127, 8'd127, 8'd127, 1'b0, 1'b1));
    set_threshold(8'd254);
    send_pixel(make_pixel(8'd254, 8'd254, 8'd254, 1'b0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
    // top threshold: even white is never bright
    set_threshold(8'd255);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
  endtask

  // one row longer than MAX_WIDTH; the tail shares the last column
  task automatic test_column_saturation();
    bit         last;
    bit         lit;
    logic [7:0] level;
    set_threshold(8'd200);
    for (int c = 0; c < MAX_WIDTH + 4; c++) begin
      last  = (c == MAX_WIDTH + 3);
      lit   = (c == 5) || (c >= MAX_WIDTH - 6);
      level = lit ? 8'd255 : 8'($urandom_range(0, 200));
      send_pixel(make_pixel(level, level, level, last, last));
    end
  endtask

  // more rows than MAX_HEIGHT, one pixel each
  task automatic test_row_saturation();
    bit         last;
    bit         lit;
    logic [7:0] level;
    set_threshold(8'd100);
    for (int r = 0; r < MAX_HEIGHT + 4; r++) begin
      last  = (r == MAX_HEIGHT + 3);
      lit   = (r == 3) || (r >= MAX_HEIGHT - 4);
      level = lit ? 8'($urandom_range(101, 255)) : 8'($urandom_range(0, 100));
      send_pixel(make_pixel(level, level, level, 1'b1, last));
    end
  endtask

  // receiver holds off while one pixel frames arrive back to back, so the
  // result queue fills and full stalls the input; then the sender waits
  // for every result
  task automatic test_queue_backpressure();
    set_threshold(8'($urandom_range(1, 254)));
    pace_enable  = 1'b0;
    hold_request = 1'b1;
    repeat (40)
      send_pixel(make_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom), 1'b1));
    pace_enable = 1'b1;
    drain_results();
  endtask

  // phases over several thresholds, extremes first
  task automatic test_random_frames();
    int         goal;
    int         phase_goal;
    int         phase;
    logic [7:0] level;
    goal  = pixels_sent + RANDOM_PIXELS;
    phase = 0;
    while (pixels_sent < goal) begin
      case (phase)
        0:       level = 8'd0;
        1:       level = 8'd255;
        2:       level = 8'd1;
        3:       level = 8'd254;
        default: level = 8'($urandom);
      endcase
      set_threshold(level);
      phase_goal = pixels_sent + $urandom_range(150, 400);
      while (pixels_sent < phase_goal) begin
        case ($urandom_range(0, 9))
          0:       send_noise($urandom_range(1, 12));
          1:       send_frame(1'b1);
          default: send_frame(1'b0);
        endcase
      end
      // close whatever frame the noise left open
      send_frame(1'b0);
      phase++;
    end
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  initial begin : main_sequence
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_pixels();
    test_column_saturation();
    test_row_saturation();
    test_queue_backpressure();
    test_random_frames();
    drain_results();
    if (mismatch_count == 0) begin
      $display("thresholded_brightness_centroid_unit regression: pass");
    end else begin
      $display("thresholded_brightness_centroid_unit regression: fail");
    end
    $finish;
  end

  // generous bound over the slowest legal run
  initial begin : run_limit
    #20_000_000;
    $display("thresholded_brightness_centroid_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tbc_pkg.sv
rtl/tbc_front.sv
rtl/tbc_queue.sv
rtl/tbc_back.sv
rtl/thresholded_brightness_centroid_unit.sv
tb/thresholded_brightness_centroid_unit_test.sv
